// ===== hdl/smm_pkg.sv =====
// Shared types, constants and helpers of the stereo matrix mixer.
// Used by every module of the mixer; depends on nothing.
`default_nettype none

package smm_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int PEAK_W       = 15;
	localparam int NUM_SOURCES  = 3;
	localparam int MAX_BUSES    = 2;
	localparam int NUM_BUSES_C  = 2;
	localparam int GAIN_BITS_C  = 10;
	localparam int Q_FRAC       = 8;
	localparam int SAMPLE_MAX   = 32767;
	localparam int SAMPLE_MIN   = -32768;

	localparam int ROUTE_GAIN_W = 60;
	localparam int ROUTE_EN_W   = 6;
	localparam int SRC_MASK_W   = 3;
	localparam int BUS_GAIN_W   = 20;
	localparam int BUS_MASK_W   = 2;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 60;
	localparam int KIND_W       = 2;
	localparam int INDEX_W      = 2;
	localparam int SRC_W        = 2;

	localparam logic [ROUTE_GAIN_W-1:0] ROUTE_GAIN_RST = '0;
	localparam logic [ROUTE_EN_W-1:0]   ROUTE_EN_RST   = 6'd16;
	localparam logic [BUS_GAIN_W-1:0]   BUS_GAIN_RST   = 20'd262400;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROUTE_GAIN = 3'd0,
		REG_ROUTE_EN   = 3'd1,
		REG_SRC_MUTE   = 3'd2,
		REG_SRC_SOLO   = 3'd3,
		REG_BUS_GAIN   = 3'd4,
		REG_BUS_MUTE   = 3'd5
	} cfg_reg_t;

	localparam logic [KIND_W-1:0] KIND_MIX      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SRC_PEAK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BUS_PEAK = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUTE,
		ST_GAP,
		ST_BUS,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_ROUTE,
		OP_BUS
	} op_t;

	typedef struct packed {
		logic [ROUTE_GAIN_W-1:0] route_gain;
		logic [ROUTE_EN_W-1:0]   route_en;
		logic [SRC_MASK_W-1:0]   src_mute;
		logic [SRC_MASK_W-1:0]   src_solo;
		logic [BUS_GAIN_W-1:0]   bus_gain;
		logic [BUS_MASK_W-1:0]   bus_mute;
	} cfg_t;

	typedef struct packed {
		logic              capture;
		op_t               op;
		logic [SRC_W-1:0]  src;
		logic              bus;
		logic              load;
		logic [KIND_W-1:0] kind;
		logic [INDEX_W-1:0] index;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	// -32768 saturates to 32767
	function automatic logic [PEAK_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] v);
		logic [SAMPLE_W-1:0] neg;
		neg = SAMPLE_W'(-v);
		if (!v[SAMPLE_W-1])
			return v[PEAK_W-1:0];
		else if (v == SAMPLE_W'(SAMPLE_MIN))
			return PEAK_W'(SAMPLE_MAX);
		else
			return neg[PEAK_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/smm_cfg.sv =====
// Configuration register file of the mixer: decodes indexed writes.
// Depends on smm_pkg.
`default_nettype none

module smm_cfg (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [smm_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire  [smm_pkg::CFG_DATA_W-1:0]       cfg_data,
	output smm_pkg::cfg_t                        cfg_o
);
	import smm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg_o     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.route_gain <= ROUTE_GAIN_RST;
			cfg_q.route_en   <= ROUTE_EN_RST;
			cfg_q.src_mute   <= '0;
			cfg_q.src_solo   <= '0;
			cfg_q.bus_gain   <= BUS_GAIN_RST;
			cfg_q.bus_mute   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			// drop writes to unknown indexes
			unique case (cfg_index)
				REG_ROUTE_GAIN: cfg_q.route_gain <= cfg_data[ROUTE_GAIN_W-1:0];
				REG_ROUTE_EN:   cfg_q.route_en   <= cfg_data[ROUTE_EN_W-1:0];
				REG_SRC_MUTE:   cfg_q.src_mute   <= cfg_data[SRC_MASK_W-1:0];
				REG_SRC_SOLO:   cfg_q.src_solo   <= cfg_data[SRC_MASK_W-1:0];
				REG_BUS_GAIN:   cfg_q.bus_gain   <= cfg_data[BUS_GAIN_W-1:0];
				REG_BUS_MUTE:   cfg_q.bus_mute   <= cfg_data[BUS_MASK_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/smm_datapath.sv =====
// Mixer datapath: sample capture, shared gain multipliers, bus accumulators,
// peak meters and the output register. Depends on smm_pkg.
`default_nettype none

module smm_datapath #(
	parameter int GAIN_BITS = smm_pkg::GAIN_BITS_C
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  smm_pkg::cfg_t                         cfg_i,
	input  smm_pkg::cmd_t                         cmd_i,
	output smm_pkg::status_t                      status_o,
	input  wire signed [smm_pkg::SAMPLE_W-1:0]    smp_in [smm_pkg::NUM_SOURCES][2],
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic [smm_pkg::KIND_W-1:0]            result_kind,
	output logic [smm_pkg::INDEX_W-1:0]           result_index,
	output logic signed [smm_pkg::SAMPLE_W-1:0]   left_value,
	output logic signed [smm_pkg::SAMPLE_W-1:0]   right_value,
	output logic                                  last_result
);
	import smm_pkg::*;

	localparam int TERM_W  = SAMPLE_W + GAIN_BITS + 1 - Q_FRAC;
	localparam int ACC_W   = TERM_W + 2;
	localparam int MUL_W   = ACC_W + GAIN_BITS + 1;
	localparam int SH_W    = MUL_W - Q_FRAC;
	localparam int RG_EXT  = 6 * GAIN_BITS + ROUTE_GAIN_W;
	localparam int BG_EXT  = 2 * GAIN_BITS + BUS_GAIN_W;

	logic signed [SAMPLE_W-1:0] smp_q      [NUM_SOURCES][2];
	logic        [PEAK_W-1:0]   src_peak_q [NUM_SOURCES][2];
	logic        [PEAK_W-1:0]   bus_peak_q [MAX_BUSES][2];
	logic signed [ACC_W-1:0]    acc_q      [MAX_BUSES][2];
	logic signed [SAMPLE_W-1:0] bus_out_q  [MAX_BUSES][2];
	logic signed [MUL_W-1:0]    prod_s1    [2];
	op_t                        op_s1;
	logic                       bus_s1;

	logic [RG_EXT-1:0]          route_ext;
	logic [BG_EXT-1:0]          bus_ext;
	logic [2:0]                 route;
	logic                       route_on;
	logic [GAIN_BITS-1:0]       gain;
	logic signed [ACC_W-1:0]    op_a   [2];
	logic signed [MUL_W-1:0]    prod   [2];
	logic signed [SH_W-1:0]     shifted[2];
	logic signed [SAMPLE_W-1:0] clamped[2];
	logic                       out_free;

	assign route_ext = RG_EXT'(cfg_i.route_gain);
	assign bus_ext   = BG_EXT'(cfg_i.bus_gain);
	assign route     = {cmd_i.src, cmd_i.bus};
	assign route_on  = cfg_i.route_en[route] && !cfg_i.src_mute[cmd_i.src] &&
		(cfg_i.src_solo == '0 || cfg_i.src_solo[cmd_i.src]);

	// a disabled route, a muted or unsoloed source, or a muted bus multiplies by zero
	always_comb begin
		gain = '0;
		unique case (cmd_i.op)
			OP_ROUTE: if (route_on) gain = route_ext[route*GAIN_BITS +: GAIN_BITS];
			OP_BUS:   if (!cfg_i.bus_mute[cmd_i.bus])
				gain = bus_ext[cmd_i.bus*GAIN_BITS +: GAIN_BITS];
			default: ;
		endcase
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			op_a[c] = (cmd_i.op == OP_BUS) ? acc_q[cmd_i.bus][c]
				: ACC_W'(smp_q[cmd_i.src][c]);
			prod[c] = op_a[c] * $signed({1'b0, gain});
			shifted[c] = SH_W'(prod_s1[c] >>> Q_FRAC);
			if (shifted[c] > $signed(SH_W'(SAMPLE_MAX)))
				clamped[c] = SAMPLE_W'(SAMPLE_MAX);
			else if (shifted[c] < $signed(SH_W'(SAMPLE_MIN)))
				clamped[c] = SAMPLE_W'(SAMPLE_MIN);
			else
				clamped[c] = shifted[c][SAMPLE_W-1:0];
		end
	end

	assign out_free          = !out_valid || !out_stall;
	assign status_o.out_free = out_free;

	always_ff @(posedge clk) begin
		if (cmd_i.capture)
			smp_q <= smp_in;
		prod_s1[0] <= prod[0];
		prod_s1[1] <= prod[1];
		bus_s1     <= cmd_i.bus;
		if (cmd_i.capture) begin
			for (int b = 0; b < MAX_BUSES; b++) begin
				acc_q[b][0] <= '0;
				acc_q[b][1] <= '0;
			end
		end else if (op_s1 == OP_ROUTE) begin
			for (int c = 0; c < 2; c++)
				acc_q[bus_s1][c] <= acc_q[bus_s1][c] + ACC_W'(shifted[c]);
		end
		if (op_s1 == OP_BUS) begin
			bus_out_q[bus_s1][0] <= clamped[0];
			bus_out_q[bus_s1][1] <= clamped[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
			for (int s = 0; s < NUM_SOURCES; s++) begin
				src_peak_q[s][0] <= '0;
				src_peak_q[s][1] <= '0;
			end
			for (int b = 0; b < MAX_BUSES; b++) begin
				bus_peak_q[b][0] <= '0;
				bus_peak_q[b][1] <= '0;
			end
		end else begin
			op_s1 <= cmd_i.op;
			if (cmd_i.capture) begin
				for (int s = 0; s < NUM_SOURCES; s++)
					for (int c = 0; c < 2; c++)
						if (magnitude(smp_in[s][c]) > src_peak_q[s][c])
							src_peak_q[s][c] <= magnitude(smp_in[s][c]);
			end
			if (op_s1 == OP_BUS) begin
				for (int c = 0; c < 2; c++)
					if (magnitude(clamped[c]) > bus_peak_q[bus_s1][c])
						bus_peak_q[bus_s1][c] <= magnitude(clamped[c]);
			end
			// clear a meter as its item is loaded
			if (cmd_i.load && cmd_i.kind == KIND_SRC_PEAK) begin
				src_peak_q[cmd_i.index][0] <= '0;
				src_peak_q[cmd_i.index][1] <= '0;
			end
			if (cmd_i.load && cmd_i.kind == KIND_BUS_PEAK) begin
				bus_peak_q[cmd_i.index[0]][0] <= '0;
				bus_peak_q[cmd_i.index[0]][1] <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_free)
			out_valid <= cmd_i.load;
	end

	always_ff @(posedge clk) begin
		if (cmd_i.load && out_free) begin
			result_kind  <= cmd_i.kind;
			result_index <= cmd_i.index;
			last_result  <= cmd_i.last;
			unique case (cmd_i.kind)
				KIND_MIX: begin
					left_value  <= bus_out_q[cmd_i.index[0]][0];
					right_value <= bus_out_q[cmd_i.index[0]][1];
				end
				KIND_SRC_PEAK: begin
					left_value  <= {1'b0, src_peak_q[cmd_i.index][0]};
					right_value <= {1'b0, src_peak_q[cmd_i.index][1]};
				end
				KIND_BUS_PEAK: begin
					left_value  <= {1'b0, bus_peak_q[cmd_i.index[0]][0]};
					right_value <= {1'b0, bus_peak_q[cmd_i.index[0]][1]};
				end
				default: begin
					left_value  <= '0;
					right_value <= '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/smm_ctrl.sv =====
// Mixer sequencer: steps the route and bus multiplies, then emits results.
// Depends on smm_pkg.
`default_nettype none

module smm_ctrl #(
	parameter int NUM_BUSES = smm_pkg::NUM_BUSES_C
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire               chunk_end,
	input  smm_pkg::status_t  status_i,
	output smm_pkg::cmd_t     cmd_o
);
	import smm_pkg::*;

	localparam logic BUS_LAST = 1'(NUM_BUSES - 1);
	localparam logic [SRC_W-1:0]   SRC_LAST = SRC_W'(NUM_SOURCES - 1);
	localparam logic [INDEX_W-1:0] IDX_BUS_LAST = INDEX_W'(NUM_BUSES - 1);

	state_t             state_q, state_d;
	logic [SRC_W-1:0]   src_q, src_d;
	logic               bus_q, bus_d;
	logic [KIND_W-1:0]  kind_q, kind_d;
	logic [INDEX_W-1:0] idx_q, idx_d;
	logic               chunk_q, chunk_d;
	logic               last_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			src_q   <= '0;
			bus_q   <= 1'b0;
			kind_q  <= KIND_MIX;
			idx_q   <= '0;
			chunk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			src_q   <= src_d;
			bus_q   <= bus_d;
			kind_q  <= kind_d;
			idx_q   <= idx_d;
			chunk_q <= chunk_d;
		end
	end

	always_comb begin
		state_d = state_q;
		src_d   = src_q;
		bus_d   = bus_q;
		kind_d  = kind_q;
		idx_d   = idx_q;
		chunk_d = chunk_q;
		in_stall      = 1'b1;
		cmd_o.capture = 1'b0;
		cmd_o.op      = OP_NONE;
		cmd_o.src     = src_q;
		cmd_o.bus     = bus_q;
		cmd_o.load    = 1'b0;
		cmd_o.kind    = kind_q;
		cmd_o.index   = idx_q;
		last_item = (kind_q == KIND_BUS_PEAK && idx_q == IDX_BUS_LAST) ||
			(kind_q == KIND_MIX && idx_q == IDX_BUS_LAST && !chunk_q);
		cmd_o.last    = last_item;

		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd_o.capture = 1'b1;
					chunk_d = chunk_end;
					src_d   = '0;
					bus_d   = 1'b0;
					state_d = ST_ROUTE;
				end
			end
			ST_ROUTE: begin
				cmd_o.op = OP_ROUTE;
				if (bus_q == BUS_LAST) begin
					bus_d = 1'b0;
					src_d = src_q + SRC_W'(1);
					if (src_q == SRC_LAST)
						state_d = ST_GAP;
				end else begin
					bus_d = 1'b1;
				end
			end
			// let the last route product settle into its accumulator
			ST_GAP: begin
				src_d   = '0;
				bus_d   = 1'b0;
				state_d = ST_BUS;
			end
			ST_BUS: begin
				cmd_o.op = OP_BUS;
				if (bus_q == BUS_LAST) begin
					bus_d   = 1'b0;
					state_d = ST_DRAIN;
				end else begin
					bus_d = 1'b1;
				end
			end
			ST_DRAIN: begin
				kind_d  = KIND_MIX;
				idx_d   = '0;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status_i.out_free) begin
					cmd_o.load = 1'b1;
					idx_d = idx_q + INDEX_W'(1);
					if (last_item) begin
						state_d = ST_IDLE;
					end else if (kind_q == KIND_MIX && idx_q == IDX_BUS_LAST) begin
						kind_d = KIND_SRC_PEAK;
						idx_d  = '0;
					end else if (kind_q == KIND_SRC_PEAK && idx_q == INDEX_W'(SRC_LAST)) begin
						kind_d = KIND_BUS_PEAK;
						idx_d  = '0;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.load |-> status_i.out_free)
		else $error("result loaded while output register is occupied");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_o.load && cmd_o.last) |=> (state_q == ST_IDLE && !in_stall))
		else $error("sequencer did not return to idle after last result");

	a_capture_starts_route: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.capture |=> (state_q == ST_ROUTE && src_q == '0 && !bus_q))
		else $error("capture did not restart the route sequence");

endmodule

`default_nettype wire

// ===== hdl/stereo_matrix_mixer_with_metering.sv =====
// Stereo matrix mixer with mute, solo and peak metering.
// A frame is taken only while the sequencer is idle. It steps both channels of
// every route and bus through one shared multiplier pair, then emits one mix result
// per bus, plus source and bus meter results if chunk_end was set, before the next.
// Reset: arst_n clears meters, sequencer and output valid; registers take defaults.
// Depends on smm_pkg, smm_cfg, smm_datapath and smm_ctrl.
`default_nettype none

module stereo_matrix_mixer_with_metering #(
	parameter int NUM_BUSES = smm_pkg::NUM_BUSES_C,
	parameter int GAIN_BITS = smm_pkg::GAIN_BITS_C
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [smm_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire  [smm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire signed [smm_pkg::SAMPLE_W-1:0]   line_a_left,
	input  wire signed [smm_pkg::SAMPLE_W-1:0]   line_a_right,
	input  wire signed [smm_pkg::SAMPLE_W-1:0]   line_b_left,
	input  wire signed [smm_pkg::SAMPLE_W-1:0]   line_b_right,
	input  wire signed [smm_pkg::SAMPLE_W-1:0]   synth_left,
	input  wire signed [smm_pkg::SAMPLE_W-1:0]   synth_right,
	input  wire                                  chunk_end,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [smm_pkg::KIND_W-1:0]           result_kind,
	output logic [smm_pkg::INDEX_W-1:0]          result_index,
	output logic signed [smm_pkg::SAMPLE_W-1:0]  left_value,
	output logic signed [smm_pkg::SAMPLE_W-1:0]  right_value,
	output logic                                 last_result
);
	import smm_pkg::*;

	cfg_t                       cfg;
	cmd_t                       cmd;
	status_t                    status;
	logic signed [SAMPLE_W-1:0] smp [NUM_SOURCES][2];

	assign smp[0][0] = line_a_left;
	assign smp[0][1] = line_a_right;
	assign smp[1][0] = line_b_left;
	assign smp[1][1] = line_b_right;
	assign smp[2][0] = synth_left;
	assign smp[2][1] = synth_right;

	smm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_o     (cfg)
	);

	smm_ctrl #(
		.NUM_BUSES (NUM_BUSES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.chunk_end (chunk_end),
		.status_i  (status),
		.cmd_o     (cmd)
	);

	smm_datapath #(
		.GAIN_BITS (GAIN_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_i        (cfg),
		.cmd_i        (cmd),
		.status_o     (status),
		.smp_in       (smp),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.result_index (result_index),
		.left_value   (left_value),
		.right_value  (right_value),
		.last_result  (last_result)
	);

endmodule

`default_nettype wire
